// ===== rtl/core/rdx_pkg.sv =====
package rdx_pkg;

   // Field widths of the transactions and the configuration port
   localparam int VALUE_W   = 64;
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int RADIX_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 64;

   // Largest usable radix (digit values must fit DIGIT_W bits)
   localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(16);
   localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);

   // Default digit store depth
   localparam int DEF_MAX_DIGITS = 64;

   // The divider consumes this many dividend bits per cycle
   localparam int BITS_PER_STEP = 8;
   localparam int STEPS_PER_DIV = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(STEPS_PER_DIV);

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_LOW  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_HIGH = CSR_IDX_W'(2);

   // Reset values: radix ten and the alphabet "0123456789"
   localparam logic [RADIX_W-1:0] RADIX_RESET      = RADIX_W'(10);
   localparam logic [CSR_W-1:0]   CHARS_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_W-1:0]   CHARS_HIGH_RESET = 64'h0000_0000_0000_3938;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;     // load a new value and clear the digit count
      logic div_step;  // run one step of the digit division
      logic read;      // fetch the digit under the read pointer
      logic advance;   // move the read pointer to the next digit
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_last;  // this step completes one digit
      logic conv_end;  // no further digit follows this one
      logic ptr_zero;  // read pointer sits on the least significant digit
   } status_type;

endpackage

// ===== rtl/core/integer_to_radix_digits_unit.sv =====
// Each digit is divided out with the divider taking 8 dividend bits a cycle;
// each character is then a digit store read followed by output, where the
// receiver can stall it. The block takes one transaction at a time.
// Reset clears the controller and restores radix ten and the "0123456789"
// alphabet; the digit store is not cleared and needs no clearing pass.
module integer_to_radix_digits_unit #(
   parameter int MAX_DIGITS = rdx_pkg::DEF_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rdx_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rdx_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic                          rsp_last_digit,
   input  logic                          csr_we,
   input  logic [rdx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rdx_pkg::CSR_W-1:0]     csr_wdata
);
   import rdx_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [RADIX_W-1:0] eff_radix;
   logic [CSR_W-1:0]   chars_low;
   logic [CSR_W-1:0]   chars_high;

   // Configuration registers
   rdx_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .eff_radix  (eff_radix),
      .chars_low  (chars_low),
      .chars_high (chars_high)
   );

   // Sequencing of division and character output
   rdx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Divider, digit store and alphabet lookup
   rdx_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .eff_radix      (eff_radix),
      .chars_low      (chars_low),
      .chars_high     (chars_high),
      .rsp_char_code  (rsp_char_code),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

// ===== rtl/core/rdx_csr.sv =====
module rdx_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rdx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rdx_pkg::CSR_W-1:0]      csr_wdata,
   output logic [rdx_pkg::RADIX_W-1:0]    eff_radix,
   output logic [rdx_pkg::CSR_W-1:0]      chars_low,
   output logic [rdx_pkg::CSR_W-1:0]      chars_high
);
   import rdx_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic [CSR_W-1:0]   chars_low_ff;
   logic [CSR_W-1:0]   chars_high_ff;

   // Register writes; an index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         chars_low_ff  <= CHARS_LOW_RESET;
         chars_high_ff <= CHARS_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIX:      radix_ff      <= csr_wdata[RADIX_W-1:0];
            CSR_CHARS_LOW:  chars_low_ff  <= csr_wdata;
            CSR_CHARS_HIGH: chars_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the radix into the usable range
   always_comb begin
      if (radix_ff < MIN_RADIX) begin
         eff_radix = MIN_RADIX;
      end else if (radix_ff > MAX_RADIX) begin
         eff_radix = MAX_RADIX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   assign chars_low  = chars_low_ff;
   assign chars_high = chars_high_ff;

endmodule

// ===== rtl/core/rdx_datapath.sv =====
module rdx_datapath #(
   parameter int MAX_DIGITS = rdx_pkg::DEF_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rdx_pkg::cmd_type              cmd,
   output rdx_pkg::status_type           status,
   input  logic [rdx_pkg::VALUE_W-1:0]   req_value,
   input  logic [rdx_pkg::RADIX_W-1:0]   eff_radix,
   input  logic [rdx_pkg::CSR_W-1:0]     chars_low,
   input  logic [rdx_pkg::CSR_W-1:0]     chars_high,
   output logic [rdx_pkg::CHAR_W-1:0]    rsp_char_code,
   output logic                          rsp_last_digit
);
   import rdx_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   logic [VALUE_W-1:0]       quot_ff;
   logic [VALUE_W-1:0]       quot_in;
   logic [DIGIT_W-1:0]       rem_ff;
   logic [DIGIT_W-1:0]       rem_in;
   logic [RADIX_W-1:0]       radix_ff;
   logic [STEP_CNT_W-1:0]    step_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [IDX_W-1:0]         rd_ptr_ff;
   logic [DIGIT_W-1:0]       rd_data_ff;
   logic [DIGIT_W-1:0]       digit_mem [MAX_DIGITS];
   logic [BITS_PER_STEP-1:0] quot_bits;
   logic [BITS_PER_STEP-1:0] top_bits;
   logic                     step_last;

   // Restoring division of the top dividend bits by the radix, one bit per
   // iteration; the partial remainder stays below the radix, so four bits do.
   always_comb begin
      logic [RADIX_W-1:0] trial;
      logic [DIGIT_W-1:0] rem;
      rem      = rem_ff;
      top_bits = quot_ff[VALUE_W-1 -: BITS_PER_STEP];
      for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
         trial = {rem, top_bits[i]};
         if (trial >= radix_ff) begin
            quot_bits[i] = 1'b1;
            trial        = trial - radix_ff;
         end else begin
            quot_bits[i] = 1'b0;
         end
         rem = trial[DIGIT_W-1:0];
      end
      rem_in  = rem;
      quot_in = {quot_ff[VALUE_W-BITS_PER_STEP-1:0], quot_bits};
   end

   assign step_last = (step_ff == STEP_CNT_W'(STEPS_PER_DIV - 1));

   // Quotient, remainder, step counter and digit count of the division
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.start) begin
         step_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + STEP_CNT_W'(1);
         if (step_last) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         quot_ff  <= req_value;
         rem_ff   <= '0;
         radix_ff <= eff_radix;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= step_last ? '0 : rem_in;
      end
   end

   // Digit store: one write port for finished digits, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.div_step && step_last) begin
         digit_mem[count_ff[IDX_W-1:0]] <= rem_in;
      end
      if (cmd.read) begin
         rd_data_ff <= digit_mem[rd_ptr_ff];
      end
   end

   // Read pointer starts on the most significant digit and walks down
   always_ff @(posedge clock) begin
      if (cmd.div_step && step_last) begin
         rd_ptr_ff <= count_ff[IDX_W-1:0];
      end else if (cmd.advance) begin
         rd_ptr_ff <= rd_ptr_ff - IDX_W'(1);
      end
   end

   assign status.div_last = step_last;
   assign status.conv_end = (quot_in == '0) || (count_ff == CNT_W'(MAX_DIGITS - 1));
   assign status.ptr_zero = (rd_ptr_ff == '0);

   // Map the fetched digit through the alphabet
   always_comb begin
      logic [CSR_W-1:0] word;
      word          = rd_data_ff[DIGIT_W-1] ? chars_high : chars_low;
      rsp_char_code = word[{rd_data_ff[DIGIT_W-2:0], 3'b000} +: CHAR_W];
   end

   assign rsp_last_digit = (rd_ptr_ff == '0);

endmodule

// ===== rtl/core/rdx_ctrl.sv =====
module rdx_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rdx_pkg::status_type status,
   output rdx_pkg::cmd_type    cmd
);
   import rdx_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd.start    = 1'b0;
      cmd.div_step = 1'b0;
      cmd.read     = 1'b0;
      cmd.advance  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last && status.conv_end) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (status.ptr_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/rdx_checker.sv =====
module rdx_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rdx_pkg::CHAR_W-1:0]    rsp_char_code,
   input logic                          rsp_last_digit
);

   // A stalled character holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code)
                                   && $stable(rsp_last_digit))
      else $error("stalled response changed");

   // No new transaction is taken while a character is offered
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while a response is pending");

   // Division starts right after an accepted request
   a_start_div: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("block not busy after an accepted request");

   // The final character returns the block to idle
   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_digit |=> req_ready && !rsp_valid)
      else $error("block not idle after the last digit");

   // Any other character is followed by a digit store read cycle
   a_next_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_digit |=> !rsp_valid && !req_ready)
      else $error("unexpected state after a digit transaction");

endmodule

bind integer_to_radix_digits_unit rdx_checker u_rdx_checker (.*);

// ===== tb/tb.sv =====
module tb;
   import rdx_pkg::*;

   // Run limits and sizes
   localparam int DIGITS_MAX     = DEF_MAX_DIGITS;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_TAIL     = 700;
   localparam int BATCH_ITEMS    = 36;
   localparam int BATCHES        = 4;

   // Index that maps to no register; writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = CSR_IDX_W'(3);

   // One expected character of a conversion
   typedef struct packed {
      int                item_id;
      logic [CHAR_W-1:0] char_code;
      logic              last_digit;
   } digit_char_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [VALUE_W-1:0]   req_value      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [CHAR_W-1:0]    rsp_char_code;
   logic                 rsp_last_digit;
   logic                 csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [CSR_W-1:0]     csr_wdata      = '0;

   // Shadow copy of the configuration registers
   logic [RADIX_W-1:0] cfg_radix      = RADIX_RESET;
   logic [CSR_W-1:0]   cfg_chars_low  = CHARS_LOW_RESET;
   logic [CSR_W-1:0]   cfg_chars_high = CHARS_HIGH_RESET;

   digit_char_type expected_chars[$];

   int send_idle_pct  = 33;
   int recv_idle_pct  = 46;
   int values_sent    = 0;
   int chars_checked  = 0;
   int csr_writes     = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;

   integer_to_radix_digits_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_code  (rsp_char_code),
      .rsp_last_digit (rsp_last_digit),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Clock generation
   initial begin
      forever #5 clock = ~clock;
   end

   // Prints one mismatch and counts it.
   task automatic report_mismatch(input string msg);
      $display("tb: mismatch: %s", msg);
      mismatch_count++;
   endtask

   // Radix as the block uses it: clamped to the range two to sixteen.
   function automatic logic [RADIX_W-1:0] effective_base();
      if (cfg_radix < MIN_RADIX) return MIN_RADIX;
      if (cfg_radix > MAX_RADIX) return MAX_RADIX;
      return cfg_radix;
   endfunction

   // Works out the characters of one value, most significant digit first.
   function automatic void predict_characters(input logic [VALUE_W-1:0] v);
      logic [RADIX_W-1:0] base;
      logic [VALUE_W-1:0] q;
      logic [DIGIT_W-1:0] digits [DIGITS_MAX];
      logic [2*CSR_W-1:0] alphabet;
      int                 n;
      digit_char_type     c;
      base     = effective_base();
      alphabet = {cfg_chars_high, cfg_chars_low};
      q        = v;
      n        = 0;
      do begin
         digits[n] = DIGIT_W'(q % base);
         q         = q / base;
         n++;
      end while (q != 0 && n < DIGITS_MAX);
      for (int k = n - 1; k >= 0; k--) begin
         c.item_id    = values_sent;
         c.char_code  = alphabet[CHAR_W*digits[k] +: CHAR_W];
         c.last_digit = (k == 0);
         expected_chars.push_back(c);
      end
   endfunction

   // Sends one value as a request transaction and records its characters.
   task automatic send_value(input logic [VALUE_W-1:0] v);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_characters(v);
      values_sent++;
   endtask

   // Drops the request and waits until every expected character has come.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // Writes one register for a single cycle and updates the shadow copy.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_RADIX:      cfg_radix      = data[RADIX_W-1:0];
         CSR_CHARS_LOW:  cfg_chars_low  = data;
         CSR_CHARS_HIGH: cfg_chars_high = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Writes the radix with random bits above the five that count.
   task automatic write_radix(input logic [RADIX_W-1:0] r);
      logic [CSR_W-1:0] data;
      data              = {$urandom, $urandom};
      data[RADIX_W-1:0] = r;
      write_register(CSR_RADIX, data);
   endtask

   // Picks a new setting of all three registers, extremes included.
   task automatic randomise_settings();
      logic [RADIX_W-1:0] r;
      case ($urandom_range(0, 5))
         0: r = MIN_RADIX;
         1: r = MAX_RADIX;
         2: r = RADIX_W'($urandom_range(0, 1));
         3: r = RADIX_W'($urandom_range(17, 31));
         default: r = RADIX_W'($urandom_range(2, 16));
      endcase
      write_radix(r);
      write_register(CSR_CHARS_LOW,
                     ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom});
      write_register(CSR_CHARS_HIGH,
                     ($urandom_range(0, 7) == 0) ? '0 : {$urandom, $urandom});
   endtask

   // Random value: full width, shortened, zero or all ones, or near a power of the radix.
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] p;
      logic [RADIX_W-1:0] base;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 1) ? '1 : '0;
         1: begin
            base = effective_base();
            p    = VALUE_W'(1);
            repeat ($urandom_range(0, 63)) begin
               if (p <= {VALUE_W{1'b1}} / base) p = p * base;
            end
            v = p - VALUE_W'($urandom_range(0, 1));
         end
         2, 3, 4, 5: v = v >> $urandom_range(1, 63);
         default: ;
      endcase
      return v;
   endfunction

   // Values under the reset radix and alphabet.
   task automatic test_reset_defaults();
      send_value('0);
      send_value(64'd1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'd10000000000000000000);
      send_value('1);
   endtask

   // Radix settings at and beyond both ends of the usable range.
   task automatic test_radix_clamp();
      logic [RADIX_W-1:0] settings [6];
      settings = '{RADIX_W'(0), RADIX_W'(1), MIN_RADIX, MAX_RADIX, RADIX_W'(17), '1};
      foreach (settings[i]) begin
         wait_until_drained();
         write_radix(settings[i]);
         send_value('1);
      end
      send_value('0);
   endtask

   // Every digit value through programmed alphabets.
   task automatic test_alphabet();
      wait_until_drained();
      write_radix(MAX_RADIX);
      write_register(CSR_CHARS_LOW, {$urandom, $urandom});
      write_register(CSR_CHARS_HIGH, {$urandom, $urandom});
      send_value(64'h0123_4567_89AB_CDEF);
      send_value(64'hFEDC_BA98_7654_3210);
      wait_until_drained();
      write_register(CSR_CHARS_LOW, '1);
      write_register(CSR_CHARS_HIGH, '0);
      send_value(64'hF0F0_0F0F_8877_0011);
   endtask

   // A write to the unmapped index leaves every register as it was.
   task automatic test_ignored_index();
      wait_until_drained();
      write_register(CSR_UNMAPPED, '1);
      send_value(64'h0123_4567_89AB_CDEF);
      send_value('0);
   endtask

   // Random values in batches, each batch under a new setting, over three idling phases.
   task automatic test_random_items();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 46;
            end
            1: begin
               send_idle_pct = 46;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int b = 0; b < BATCHES; b++) begin
            wait_until_drained();
            randomise_settings();
            repeat (BATCH_ITEMS) send_value(pick_value());
         end
      end
   endtask

   // Receiver back-pressure, changed on the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Each response transaction is compared with the oldest expected character.
   always @(posedge clock) begin
      digit_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("character %h with nothing expected", rsp_char_code));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.char_code)
               report_mismatch($sformatf("value %0d: char_code %h, expected %h",
                                         want.item_id, rsp_char_code, want.char_code));
            if (rsp_last_digit !== want.last_digit)
               report_mismatch($sformatf("value %0d: last_digit %b, expected %b",
                                         want.item_id, rsp_last_digit, want.last_digit));
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: no transaction for %0d cycles", idle_cycles);
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Test sequence
   initial begin
      digit_char_type left;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_radix_clamp();
      test_alphabet();
      test_ignored_index();
      test_random_items();
      wait_until_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      while (expected_chars.size() != 0) begin
         left = expected_chars.pop_front();
         report_mismatch($sformatf("value %0d: character %h never arrived",
                                   left.item_id, left.char_code));
      end
      $display("tb: %0d values converted, %0d characters checked, %0d register writes",
               values_sent, chars_checked, csr_writes);
      $display("tb: radix settings from below two to above sixteen, three idling phases");
      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
